// ===== hdl/cshtab_pkg.sv =====
// shared codes, state encoding and fixed field widths of the hash table
package cshtab_pkg;

  localparam int HASH_BITS   = 32;
  localparam int CMD_BITS    = 3;
  localparam int STATUS_BITS = 2;

  localparam logic [CMD_BITS-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_GET    = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_SET    = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_ITER   = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_ITER_END  = 2'd3;

  typedef enum logic [4:0] {
    S_RST_CLR,
    S_IDLE,
    S_CLR,
    S_LK_RD,
    S_LK_CHK,
    S_INS_RD,
    S_INS_CHK,
    S_P_RD,
    S_P_CHK,
    S_W_CHK,
    S_MV_WP,
    S_MV_WF,
    S_MV_WM,
    S_NM_WM,
    S_NM_WF,
    S_FC_RD,
    S_FC_CHK,
    S_RB_DEC,
    S_RB_SCAN_RD,
    S_RB_SCAN_CHK,
    S_IT_RD,
    S_IT_CHK,
    S_DONE
  } state_t;

  typedef enum logic {
    RBR_DONE,
    RBR_RECHECK
  } rb_ret_t;

  typedef enum logic {
    PC_INSERT,
    PC_REBUILD
  } place_ctx_t;

endpackage

// ===== hdl/cshtab_if.sv =====
// valid/ready channel interfaces for commands, results and configuration
interface cshtab_in_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int POS_W      = 11
);
  import cshtab_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CMD_BITS-1:0]   command;
  logic [KEY_BITS-1:0]   key;
  logic [HASH_BITS-1:0]  key_hash;
  logic [VALUE_BITS-1:0] value;
  logic [POS_W-1:0]      position;
  modport source (output valid, command, key, key_hash, value, position, input ready);
  modport sink (input valid, command, key, key_hash, value, position, output ready);
endinterface

interface cshtab_out_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int POS_W      = 11
);
  import cshtab_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic                   inserted_new;
  logic [KEY_BITS-1:0]    out_key;
  logic [VALUE_BITS-1:0]  out_value;
  logic [POS_W-1:0]       next_position;
  logic [POS_W-1:0]       element_count;
  modport source (output valid, status, inserted_new, out_key, out_value, next_position,
                  element_count, input ready);
  modport sink (input valid, status, inserted_new, out_key, out_value, next_position,
                element_count, output ready);
endinterface

interface cshtab_cfg_if #(
  parameter int POS_W = 11
);
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hdl/cshtab_ram.sv =====
// generic simple dual port ram with registered read
module cshtab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/chained_scatter_hash_table.sv =====
// chained scatter hash table with brent relocation, sequencer around one slot ram
//
// Every slot (used flag, key, hash, value, link) sits in one ram word; two banks of
// MAX_NODES slots alternate on each rebuild. Commands run one at a time, one ram
// access per cycle: a lookup reads the home slot and follows the chain hop by hop,
// then posts the word; an insert then places the entry, walking the chain and the
// free cursor while relocating; iterate_next reads slots from the position until
// one is used or the table ends. A rebuild clears the new bank, then reads each old
// slot and inserts every live entry. After reset a clearing pass over both banks
// runs before the first command; a configuration write starts a clear of the
// active bank.
module chained_scatter_hash_table #(
  parameter int MAX_NODES  = 1024,
  parameter int MIN_NODES  = 4,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input logic          clk,
  input logic          rst_n,
  cshtab_in_if.sink    in_ch,
  cshtab_out_if.source out_ch,
  cshtab_cfg_if.sink   cfg_ch
);
  import cshtab_pkg::*;

  localparam int IDX   = $clog2(MAX_NODES);
  localparam int POS_W = IDX + 1;

  function automatic int calc_min_size();
    int s;
    s = 1;
    while (s < MIN_NODES && s < MAX_NODES) s = s * 2;
    return s;
  endfunction

  localparam int MIN_SIZE = calc_min_size();
  localparam logic [IDX-1:0]   MIN_MASK   = IDX'(MIN_SIZE - 1);
  localparam logic [IDX-1:0]   MAX_MASK   = IDX'(MAX_NODES - 1);
  localparam logic [POS_W-1:0] MIN_SIZE_P = POS_W'(MIN_SIZE);
  localparam logic [POS_W-1:0] MAX_P      = POS_W'(MAX_NODES);
  localparam logic [POS_W-1:0] HALF_MAX_P = POS_W'(MAX_NODES / 2);
  localparam logic [POS_W-1:0] FOUR_P     = POS_W'(4);

  typedef struct packed {
    logic                  used;
    logic [KEY_BITS-1:0]   key;
    logic [HASH_BITS-1:0]  hash;
    logic [VALUE_BITS-1:0] value;
    logic [POS_W-1:0]      link;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  state_t state_r, state_nxt;
  logic                   bank_r, bank_nxt;
  logic [IDX-1:0]         mask_r, mask_nxt;
  logic [IDX-1:0]         fcur_r, fcur_nxt;
  logic [POS_W-1:0]       live_r, live_nxt;
  logic [POS_W-1:0]       clr_r, clr_nxt;
  logic                   clr_cfg_r, clr_cfg_nxt;
  logic                   rb_scan_r, rb_scan_nxt;
  logic                   rb_force_r, rb_force_nxt;
  rb_ret_t                rb_ret_r, rb_ret_nxt;
  place_ctx_t             pctx_r, pctx_nxt;
  logic                   chk2_r, chk2_nxt;
  logic [CMD_BITS-1:0]    cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]    key_r, key_nxt;
  logic [HASH_BITS-1:0]   hash_r, hash_nxt;
  logic [VALUE_BITS-1:0]  val_r, val_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [IDX-1:0]         idx_r, idx_nxt;
  logic [IDX-1:0]         cnt_r, cnt_nxt;
  logic [IDX-1:0]         scan_i_r, scan_i_nxt;
  logic [IDX-1:0]         omask_r, omask_nxt;
  logic [KEY_BITS-1:0]    p_key_r, p_key_nxt;
  logic [HASH_BITS-1:0]   p_hash_r, p_hash_nxt;
  logic [VALUE_BITS-1:0]  p_val_r, p_val_nxt;
  slot_t                  rec_m_r, rec_m_nxt;
  slot_t                  rec_p_r, rec_p_nxt;
  logic [STATUS_BITS-1:0] res_status_r, res_status_nxt;
  logic                   res_fresh_r, res_fresh_nxt;
  logic [KEY_BITS-1:0]    res_okey_r, res_okey_nxt;
  logic [VALUE_BITS-1:0]  res_oval_r, res_oval_nxt;
  logic [POS_W-1:0]       res_npos_r, res_npos_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_BITS-1:0] out_status_r, out_status_nxt;
  logic                   out_fresh_r, out_fresh_nxt;
  logic [KEY_BITS-1:0]    out_okey_r, out_okey_nxt;
  logic [VALUE_BITS-1:0]  out_oval_r, out_oval_nxt;
  logic [POS_W-1:0]       out_npos_r, out_npos_nxt;
  logic [POS_W-1:0]       out_count_r, out_count_nxt;

  logic              ram_we;
  logic [IDX:0]      ram_waddr, ram_raddr;
  logic [SLOT_W-1:0] ram_wdata, ram_rdata;
  slot_t             rd;

  cshtab_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(2 * MAX_NODES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd = ram_rdata;

  logic             in_fire, cfg_fire, out_free;
  logic [IDX-1:0]   mp, fr, mph, link_idx;
  logic [POS_W-1:0] mp_link, fr_link, mask_p, pos_inc;
  logic             rd_free, lk_hit, chain_end, scan_last;
  state_t           rb_end_state;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = ((state_r == S_IDLE) && !in_ch.valid) || (state_r == S_RST_CLR);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign mp        = p_hash_r[IDX-1:0] & mask_r;
  assign fr        = fcur_r & mask_r;
  assign mph       = rd.hash[IDX-1:0] & mask_r;
  assign link_idx  = IDX'(rd.link - POS_W'(1)) & mask_r;
  assign mp_link   = {1'b0, mp} + POS_W'(1);
  assign fr_link   = {1'b0, fr} + POS_W'(1);
  assign mask_p    = {1'b0, mask_r};
  assign pos_inc   = pos_r + POS_W'(1);
  assign rd_free   = !rd.used && (rd.link == '0);
  assign lk_hit    = rd.used && (rd.key == key_r);
  assign chain_end = (rd.link == '0) || (cnt_r == mask_r);
  assign scan_last = (scan_i_r == omask_r);
  assign rb_end_state = (rb_ret_r == RBR_RECHECK) ? S_INS_RD : S_DONE;

  // size requested by a configuration write
  logic [IDX-1:0] cfg_mask;
  always_comb begin
    logic             acc;
    logic [POS_W-1:0] m;
    logic [POS_W-1:0] sm;
    m   = cfg_ch.data - POS_W'(1);
    acc = 1'b0;
    sm  = '0;
    for (int j = POS_W - 1; j >= 0; j--) begin
      acc   = acc | m[j];
      sm[j] = acc;
    end
    priority if (cfg_ch.data <= MIN_SIZE_P) begin
      cfg_mask = MIN_MASK;
    end else if (cfg_ch.data >= MAX_P) begin
      cfg_mask = MAX_MASK;
    end else begin
      cfg_mask = sm[IDX-1:0];
    end
  end

  // rebuild sizing
  logic [POS_W-1:0] old_sz, os, os_q, os_hi, ns;
  logic             rb_go;
  logic [IDX-1:0]   rb_mask;
  assign old_sz  = mask_p + POS_W'(1);
  assign os      = (old_sz < FOUR_P) ? FOUR_P : old_sz;
  assign os_q    = os >> 2;
  assign os_hi   = os - os_q;
  assign rb_mask = IDX'(ns - POS_W'(1));

  always_comb begin
    rb_go = 1'b1;
    ns    = os;
    priority if (live_r >= os_hi) begin
      if (os <= HALF_MAX_P) begin
        ns = os << 1;
      end else if (!rb_force_r) begin
        rb_go = 1'b0;
      end
    end else if (live_r <= os_q && os > MIN_SIZE_P) begin
      ns = os >> 1;
    end else if (!rb_force_r) begin
      rb_go = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RST_CLR: begin
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.command)
            CMD_INSERT, CMD_GET, CMD_SET, CMD_REMOVE: state_nxt = S_LK_RD;
            CMD_ITER:  state_nxt = S_IT_RD;
            CMD_CLEAR: state_nxt = S_RB_DEC;
            default:   state_nxt = S_DONE;
          endcase
        end else if (cfg_fire) begin
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        if (clr_r[IDX-1:0] == '1) begin
          priority if (clr_cfg_r) state_nxt = S_IDLE;
          else if (rb_scan_r)     state_nxt = S_RB_SCAN_RD;
          else                    state_nxt = rb_end_state;
        end
      end
      S_LK_RD: state_nxt = S_LK_CHK;
      S_LK_CHK: begin
        priority if (lk_hit) begin
          state_nxt = (cmd_r == CMD_REMOVE) ? S_RB_DEC : S_DONE;
        end else if (chain_end) begin
          state_nxt = (cmd_r == CMD_INSERT) ? S_INS_RD : S_DONE;
        end
      end
      S_INS_RD: state_nxt = S_INS_CHK;
      S_INS_CHK: begin
        priority if (rd_free) state_nxt = S_P_RD;
        else if (!chk2_r)     state_nxt = S_RB_DEC;
        else                  state_nxt = S_DONE;
      end
      S_P_RD: state_nxt = S_P_CHK;
      S_P_CHK: begin
        priority if (!rd.used)              state_nxt = S_FC_RD;
        else if (mp > fr && mph != mp)      state_nxt = S_W_CHK;
        else                                state_nxt = S_NM_WM;
      end
      S_W_CHK: begin
        priority if (rd.link == mp_link) state_nxt = S_MV_WP;
        else if (chain_end)              state_nxt = S_NM_WM;
      end
      S_MV_WP: state_nxt = S_MV_WF;
      S_MV_WF: state_nxt = S_MV_WM;
      S_MV_WM: state_nxt = S_FC_RD;
      S_NM_WM: state_nxt = S_NM_WF;
      S_NM_WF: state_nxt = S_FC_RD;
      S_FC_RD: state_nxt = S_FC_CHK;
      S_FC_CHK: begin
        if (rd_free || fcur_r == '0) begin
          if (pctx_r == PC_REBUILD) begin
            state_nxt = scan_last ? rb_end_state : S_RB_SCAN_RD;
          end else begin
            state_nxt = rd_free ? S_DONE : S_RB_DEC;
          end
        end
      end
      S_RB_DEC: state_nxt = rb_go ? S_CLR : rb_end_state;
      S_RB_SCAN_RD: state_nxt = S_RB_SCAN_CHK;
      S_RB_SCAN_CHK: begin
        priority if (rd.used) state_nxt = S_P_RD;
        else if (scan_last)   state_nxt = rb_end_state;
        else                  state_nxt = S_RB_SCAN_RD;
      end
      S_IT_RD: state_nxt = (pos_r > mask_p) ? S_DONE : S_IT_CHK;
      S_IT_CHK: begin
        if (rd.used || pos_inc > mask_p) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    slot_t wrec;
    bank_nxt       = bank_r;
    mask_nxt       = mask_r;
    fcur_nxt       = fcur_r;
    live_nxt       = live_r;
    clr_nxt        = clr_r;
    clr_cfg_nxt    = clr_cfg_r;
    rb_scan_nxt    = rb_scan_r;
    rb_force_nxt   = rb_force_r;
    rb_ret_nxt     = rb_ret_r;
    pctx_nxt       = pctx_r;
    chk2_nxt       = chk2_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    hash_nxt       = hash_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    scan_i_nxt     = scan_i_r;
    omask_nxt      = omask_r;
    p_key_nxt      = p_key_r;
    p_hash_nxt     = p_hash_r;
    p_val_nxt      = p_val_r;
    rec_m_nxt      = rec_m_r;
    rec_p_nxt      = rec_p_r;
    res_status_nxt = res_status_r;
    res_fresh_nxt  = res_fresh_r;
    res_okey_nxt   = res_okey_r;
    res_oval_nxt   = res_oval_r;
    res_npos_nxt   = res_npos_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_fresh_nxt  = out_fresh_r;
    out_okey_nxt   = out_okey_r;
    out_oval_nxt   = out_oval_r;
    out_npos_nxt   = out_npos_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;
    wrec           = rd;

    unique case (state_r)
      S_RST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + POS_W'(1);
        if (cfg_fire) begin
          mask_nxt = cfg_mask;
          fcur_nxt = cfg_mask;
          live_nxt = '0;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt        = in_ch.command;
          key_nxt        = in_ch.key;
          hash_nxt       = in_ch.key_hash;
          val_nxt        = in_ch.value;
          pos_nxt        = in_ch.position;
          res_status_nxt = ST_OK;
          res_fresh_nxt  = 1'b0;
          res_okey_nxt   = '0;
          res_oval_nxt   = '0;
          res_npos_nxt   = '0;
          chk2_nxt       = 1'b0;
          rb_scan_nxt    = 1'b1;
          if (in_ch.command == CMD_CLEAR) begin
            live_nxt     = '0;
            rb_force_nxt = 1'b1;
            rb_ret_nxt   = RBR_DONE;
            rb_scan_nxt  = 1'b0;
          end
        end else if (cfg_fire) begin
          mask_nxt    = cfg_mask;
          fcur_nxt    = cfg_mask;
          live_nxt    = '0;
          clr_nxt     = '0;
          clr_cfg_nxt = 1'b1;
        end
      end
      S_CLR: begin
        ram_we     = 1'b1;
        ram_waddr  = {bank_r, clr_r[IDX-1:0]};
        clr_nxt    = clr_r + POS_W'(1);
        scan_i_nxt = '0;
      end
      S_LK_RD: begin
        idx_nxt   = hash_r[IDX-1:0] & mask_r;
        cnt_nxt   = '0;
        ram_raddr = {bank_r, hash_r[IDX-1:0] & mask_r};
      end
      S_LK_CHK: begin
        priority if (lk_hit) begin
          ram_waddr = {bank_r, idx_r};
          unique case (cmd_r)
            CMD_GET: res_oval_nxt = rd.value;
            CMD_REMOVE: begin
              wrec.used    = 1'b0;
              ram_we       = 1'b1;
              ram_wdata    = wrec;
              rb_force_nxt = 1'b0;
              rb_ret_nxt   = RBR_DONE;
              if (live_r != '0) live_nxt = live_r - POS_W'(1);
            end
            default: begin
              wrec.value = val_r;
              ram_we     = 1'b1;
              ram_wdata  = wrec;
            end
          endcase
        end else if (chain_end) begin
          if (cmd_r != CMD_INSERT) res_status_nxt = ST_NOT_FOUND;
        end else begin
          idx_nxt   = link_idx;
          cnt_nxt   = cnt_r + IDX'(1);
          ram_raddr = {bank_r, link_idx};
        end
      end
      S_INS_RD: ram_raddr = {bank_r, fcur_r};
      S_INS_CHK: begin
        priority if (rd_free) begin
          p_key_nxt     = key_r;
          p_hash_nxt    = hash_r;
          p_val_nxt     = val_r;
          pctx_nxt      = PC_INSERT;
          res_fresh_nxt = 1'b1;
        end else if (!chk2_r) begin
          chk2_nxt     = 1'b1;
          rb_force_nxt = 1'b1;
          rb_ret_nxt   = RBR_RECHECK;
        end else begin
          res_status_nxt = ST_FULL;
        end
      end
      S_P_RD: ram_raddr = {bank_r, mp};
      S_P_CHK: begin
        rec_m_nxt = rd;
        live_nxt  = live_r + POS_W'(1);
        priority if (!rd.used) begin
          ram_we    = 1'b1;
          ram_waddr = {bank_r, mp};
          ram_wdata = slot_t'{1'b1, p_key_r, p_hash_r, p_val_r, rd.link};
        end else if (mp > fr && mph != mp) begin
          idx_nxt   = mph;
          cnt_nxt   = '0;
          ram_raddr = {bank_r, mph};
        end else begin
          cnt_nxt = cnt_r;
        end
      end
      S_W_CHK: begin
        priority if (rd.link == mp_link) begin
          rec_p_nxt = rd;
        end else if (!chain_end) begin
          idx_nxt   = link_idx;
          cnt_nxt   = cnt_r + IDX'(1);
          ram_raddr = {bank_r, link_idx};
        end else begin
          cnt_nxt = cnt_r;
        end
      end
      S_MV_WP: begin
        wrec      = rec_p_r;
        wrec.link = fr_link;
        ram_we    = 1'b1;
        ram_waddr = {bank_r, idx_r};
        ram_wdata = wrec;
      end
      S_MV_WF: begin
        ram_we    = 1'b1;
        ram_waddr = {bank_r, fr};
        ram_wdata = rec_m_r;
      end
      S_MV_WM: begin
        ram_we    = 1'b1;
        ram_waddr = {bank_r, mp};
        ram_wdata = slot_t'{1'b1, p_key_r, p_hash_r, p_val_r, POS_W'(0)};
      end
      S_NM_WM: begin
        wrec      = rec_m_r;
        wrec.link = fr_link;
        ram_we    = 1'b1;
        ram_waddr = {bank_r, mp};
        ram_wdata = wrec;
      end
      S_NM_WF: begin
        ram_we    = 1'b1;
        ram_waddr = {bank_r, fr};
        ram_wdata = slot_t'{1'b1, p_key_r, p_hash_r, p_val_r, rec_m_r.link};
      end
      S_FC_RD: ram_raddr = {bank_r, fcur_r};
      S_FC_CHK: begin
        if (rd_free || fcur_r == '0) begin
          if (pctx_r == PC_REBUILD) begin
            if (!scan_last) scan_i_nxt = scan_i_r + IDX'(1);
          end else if (!rd_free) begin
            rb_force_nxt = 1'b1;
            rb_ret_nxt   = RBR_DONE;
          end
        end else begin
          fcur_nxt  = fcur_r - IDX'(1);
          ram_raddr = {bank_r, fcur_r - IDX'(1)};
        end
      end
      S_RB_DEC: begin
        if (rb_go) begin
          omask_nxt   = mask_r;
          bank_nxt    = !bank_r;
          mask_nxt    = rb_mask;
          fcur_nxt    = rb_mask;
          live_nxt    = '0;
          clr_nxt     = '0;
          clr_cfg_nxt = 1'b0;
        end
      end
      S_RB_SCAN_RD: ram_raddr = {!bank_r, scan_i_r};
      S_RB_SCAN_CHK: begin
        priority if (rd.used) begin
          p_key_nxt  = rd.key;
          p_hash_nxt = rd.hash;
          p_val_nxt  = rd.value;
          pctx_nxt   = PC_REBUILD;
        end else if (!scan_last) begin
          scan_i_nxt = scan_i_r + IDX'(1);
        end else begin
          scan_i_nxt = scan_i_r;
        end
      end
      S_IT_RD: begin
        ram_raddr = {bank_r, pos_r[IDX-1:0]};
        if (pos_r > mask_p) res_status_nxt = ST_ITER_END;
      end
      S_IT_CHK: begin
        if (rd.used) begin
          res_okey_nxt = rd.key;
          res_oval_nxt = rd.value;
          res_npos_nxt = pos_inc;
        end else begin
          pos_nxt = pos_inc;
          if (pos_inc > mask_p) begin
            res_status_nxt = ST_ITER_END;
          end else begin
            ram_raddr = {bank_r, pos_inc[IDX-1:0]};
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_fresh_nxt  = res_fresh_r;
          out_okey_nxt   = res_okey_r;
          out_oval_nxt   = res_oval_r;
          out_npos_nxt   = res_npos_r;
          out_count_nxt  = live_r;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RST_CLR;
      bank_r      <= 1'b0;
      mask_r      <= MIN_MASK;
      fcur_r      <= MIN_MASK;
      live_r      <= '0;
      clr_r       <= '0;
      clr_cfg_r   <= 1'b0;
      rb_scan_r   <= 1'b0;
      rb_force_r  <= 1'b0;
      rb_ret_r    <= RBR_DONE;
      pctx_r      <= PC_INSERT;
      chk2_r      <= 1'b0;
      cnt_r       <= '0;
      scan_i_r    <= '0;
      omask_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      mask_r      <= mask_nxt;
      fcur_r      <= fcur_nxt;
      live_r      <= live_nxt;
      clr_r       <= clr_nxt;
      clr_cfg_r   <= clr_cfg_nxt;
      rb_scan_r   <= rb_scan_nxt;
      rb_force_r  <= rb_force_nxt;
      rb_ret_r    <= rb_ret_nxt;
      pctx_r      <= pctx_nxt;
      chk2_r      <= chk2_nxt;
      cnt_r       <= cnt_nxt;
      scan_i_r    <= scan_i_nxt;
      omask_r     <= omask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    hash_r       <= hash_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    p_key_r      <= p_key_nxt;
    p_hash_r     <= p_hash_nxt;
    p_val_r      <= p_val_nxt;
    rec_m_r      <= rec_m_nxt;
    rec_p_r      <= rec_p_nxt;
    res_status_r <= res_status_nxt;
    res_fresh_r  <= res_fresh_nxt;
    res_okey_r   <= res_okey_nxt;
    res_oval_r   <= res_oval_nxt;
    res_npos_r   <= res_npos_nxt;
    out_status_r <= out_status_nxt;
    out_fresh_r  <= out_fresh_nxt;
    out_okey_r   <= out_okey_nxt;
    out_oval_r   <= out_oval_nxt;
    out_npos_r   <= out_npos_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.inserted_new  = out_fresh_r;
  assign out_ch.out_key       = out_okey_r;
  assign out_ch.out_value     = out_oval_r;
  assign out_ch.next_position = out_npos_r;
  assign out_ch.element_count = out_count_r;

endmodule
